@@ design/bdq_pkg.sv @@
// Package for the bounded deque with search: command and status codes,
// sequencer states, field types and the result struct.
// No dependencies.
package bdq_pkg;

	localparam int CMD_W   = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 8;
	localparam int COUNT_W = 5;

	typedef logic [CMD_W-1:0]          cmd_field_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [POS_W-1:0]          pos_t;
	typedef logic [COUNT_W-1:0]        count_field_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_REPLACE    = 3'd4,
		CMD_SEARCH     = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SEARCH,
		S_DONE
	} state_t;

	typedef struct packed {
		status_t      status;
		logic         found;
		count_field_t entry_count;
	} result_t;

endpackage

@@ design/bdq_if.sv @@
// Valid/ready channel interfaces for the deque: command in, result out.
// Depends on bdq_pkg.
interface bdq_req_if;
	logic                valid;
	logic                ready;
	bdq_pkg::cmd_field_t cmd;
	bdq_pkg::value_t     value;
	bdq_pkg::pos_t       position;

	modport source (output valid, cmd, value, position, input ready);
	modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface bdq_rsp_if;
	logic                  valid;
	logic                  ready;
	bdq_pkg::status_t      status;
	logic                  found;
	bdq_pkg::count_field_t entry_count;

	modport source (output valid, status, found, entry_count, input ready);
	modport sink   (input valid, status, found, entry_count, output ready);
endinterface

@@ design/bdq_mem.sv @@
// Entry storage: one write port, one read port with registered read data.
// Depends on bdq_pkg.
module bdq_mem #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  bdq_pkg::value_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output bdq_pkg::value_t rdata
);

	bdq_pkg::value_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/bdq_seq.sv @@
// Command sequencer: head/count pointers, shared slot adder and the one
// comparator that walks the entries for a search.
// Depends on bdq_pkg and bdq_if.
module bdq_seq #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	bdq_req_if.sink          req,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output bdq_pkg::value_t  mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr,
	input  bdq_pkg::value_t  mem_rdata,
	output logic             res_valid,
	output bdq_pkg::result_t res,
	input  logic             res_take
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;
	localparam int PW = bdq_pkg::POS_W;
	localparam int MW = (CW > PW) ? CW : PW;

	bdq_pkg::state_t     state_q, state_d;
	bdq_pkg::cmd_field_t cmd_q;
	bdq_pkg::value_t     value_q;
	bdq_pkg::pos_t       pos_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       ptr_q;
	logic [CW-1:0]       rem_q;
	logic                pend_s1;
	bdq_pkg::status_t    status_q;
	logic                found_q;

	logic                full, empty, pos_bad, hit;
	logic [AW-1:0]       head_dec, head_inc, ptr_inc, off, slot;
	logic [SW-1:0]       sum;
	bdq_pkg::status_t    exec_status;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pos_bad  = (pos_q == '0) || (MW'(pos_q) > MW'(count_q));
	assign hit      = pend_s1 && (mem_rdata == value_q);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign ptr_inc  = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);

	// shared slot adder: head + offset, wrapped once
	assign off  = (cmd_q == bdq_pkg::CMD_REPLACE) ? AW'(pos_q - bdq_pkg::pos_t'(1))
	                                              : AW'(count_q);
	assign sum  = {1'b0, head_q} + {1'b0, off};
	assign slot = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : sum[AW-1:0];

	always_comb begin
		case (cmd_q)
			bdq_pkg::CMD_PUSH_FRONT,
			bdq_pkg::CMD_PUSH_BACK:  exec_status = full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
			bdq_pkg::CMD_POP_FRONT,
			bdq_pkg::CMD_POP_BACK,
			bdq_pkg::CMD_SEARCH:     exec_status = empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
			bdq_pkg::CMD_REPLACE: begin
				if (empty) begin
					exec_status = bdq_pkg::ST_EMPTY;
				end else if (pos_bad) begin
					exec_status = bdq_pkg::ST_BADPOS;
				end else begin
					exec_status = bdq_pkg::ST_OK;
				end
			end
			default:                 exec_status = bdq_pkg::ST_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bdq_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = bdq_pkg::S_EXEC;
				end
			end
			bdq_pkg::S_EXEC: begin
				if (cmd_q == bdq_pkg::CMD_SEARCH && !empty) begin
					state_d = bdq_pkg::S_SEARCH;
				end else begin
					state_d = bdq_pkg::S_DONE;
				end
			end
			bdq_pkg::S_SEARCH: begin
				if (hit || (rem_q == '0 && !pend_s1)) begin
					state_d = bdq_pkg::S_DONE;
				end
			end
			bdq_pkg::S_DONE: begin
				if (res_take) begin
					state_d = bdq_pkg::S_IDLE;
				end
			end
			default: state_d = bdq_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			bdq_pkg::S_IDLE: req.ready = 1'b1;
			bdq_pkg::S_EXEC: begin
				case (cmd_q)
					bdq_pkg::CMD_PUSH_FRONT,
					bdq_pkg::CMD_PUSH_BACK: mem_we = !full;
					bdq_pkg::CMD_REPLACE:   mem_we = !empty && !pos_bad;
					default:                mem_we = 1'b0;
				endcase
			end
			bdq_pkg::S_SEARCH: mem_re = !hit && (rem_q != '0);
			bdq_pkg::S_DONE:   res_valid = 1'b1;
			default: ;
		endcase
	end

	assign mem_waddr = (cmd_q == bdq_pkg::CMD_PUSH_FRONT) ? head_dec : slot;
	assign mem_wdata = value_q;
	assign mem_raddr = ptr_q;

	assign res.status      = status_q;
	assign res.found       = found_q;
	assign res.entry_count = bdq_pkg::COUNT_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == bdq_pkg::S_SEARCH) && mem_re;
			if (state_q == bdq_pkg::S_EXEC) begin
				case (cmd_q)
					bdq_pkg::CMD_PUSH_FRONT: begin
						if (!full) begin
							head_q  <= head_dec;
							count_q <= count_q + CW'(1);
						end
					end
					bdq_pkg::CMD_PUSH_BACK: begin
						if (!full) begin
							count_q <= count_q + CW'(1);
						end
					end
					bdq_pkg::CMD_POP_FRONT: begin
						if (!empty) begin
							head_q  <= head_inc;
							count_q <= count_q - CW'(1);
						end
					end
					bdq_pkg::CMD_POP_BACK: begin
						if (!empty) begin
							count_q <= count_q - CW'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bdq_pkg::S_IDLE: begin
				if (req.valid) begin
					cmd_q   <= req.cmd;
					value_q <= req.value;
					pos_q   <= req.position;
				end
			end
			bdq_pkg::S_EXEC: begin
				status_q <= exec_status;
				found_q  <= 1'b0;
				ptr_q    <= head_q;
				rem_q    <= count_q;
			end
			bdq_pkg::S_SEARCH: begin
				if (mem_re) begin
					ptr_q <= ptr_inc;
					rem_q <= rem_q - CW'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ design/bounded_deque_with_search.sv @@
// Bounded deque of signed 32-bit values with linear search.
// Push, pop, replace and ignored codes: the command is registered, run in EXEC
// and held in DONE until the output register takes the result. Search: SEARCH
// walks the entries until a hit or the last one, the single comparator reading
// one entry per cycle from the entry memory. Commands are taken only in IDLE.
// Reset empties the deque; entry contents are undefined until written.
module bounded_deque_with_search #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);

	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	bdq_pkg::value_t  mem_wdata, mem_rdata;
	logic             res_valid, res_take;
	bdq_pkg::result_t res;
	logic             rsp_valid_q;
	bdq_pkg::result_t rsp_q;

	bdq_seq #(.DEPTH(DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	bdq_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: loads when empty or when its beat leaves this cycle
	assign res_take = res_valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.found       = rsp_q.found;
	assign rsp.entry_count = rsp_q.entry_count;

endmodule

@@ dv/bounded_deque_with_search_test.sv @@
// Self-checking bench for bounded_deque_with_search: clocked driver and monitor,
// a behavioral deque predictor and a queue of expected results.
// Depends on bdq_pkg and the bdq_req_if / bdq_rsp_if interfaces.
module bounded_deque_with_search_test;
	import bdq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH          = 16;
	localparam int RANDOM_ITEMS   = 660;
	localparam int LONG_STALL     = 250;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 40;

	// Codes the block must ignore.
	localparam cmd_field_t CMD_UNUSED_6 = 3'd6;
	localparam cmd_field_t CMD_UNUSED_7 = 3'd7;

	typedef struct {
		cmd_field_t  cmd;
		value_t      value;
		pos_t        position;
		int unsigned gap;
		bit          drain;
	} deque_cmd_t;

	logic clk;
	logic arst_n;

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_deque_with_search #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deque_cmd_t cmd_pending[$];
	result_t    result_expect[$];

	// Predictor state
	value_t model_slots [DEPTH];
	int     model_head;
	int     model_count;

	value_t value_pool [12];

	bit          req_beat;
	bit          rsp_beat;
	bit          drv_offer;
	int unsigned drv_wait;
	bit          rcv_ready;
	int unsigned rcv_wait;
	int unsigned rcv_cnt;
	int unsigned rcv_burst;
	int unsigned stall_left;
	bit          stall_done;
	int unsigned stall_at;
	int unsigned idle_cycles;

	int errors;
	int cmds_taken;
	int results_seen;
	int n_full;
	int n_empty;
	int n_badpos;
	int n_search;
	int n_hits;

	function automatic result_t deque_apply(input cmd_field_t c, input value_t v,
			input pos_t p);
		result_t r;
		r.status = ST_OK;
		r.found  = 1'b0;
		case (c)
			CMD_PUSH_FRONT: begin
				if (model_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					model_head = (model_head + DEPTH - 1) % DEPTH;
					model_slots[model_head] = v;
					model_count++;
				end
			end
			CMD_PUSH_BACK: begin
				if (model_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					model_slots[(model_head + model_count) % DEPTH] = v;
					model_count++;
				end
			end
			CMD_POP_FRONT: begin
				if (model_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					model_head = (model_head + 1) % DEPTH;
					model_count--;
				end
			end
			CMD_POP_BACK: begin
				if (model_count == 0) r.status = ST_EMPTY;
				else model_count--;
			end
			CMD_REPLACE: begin
				// empty is checked ahead of the position range
				if (model_count == 0) r.status = ST_EMPTY;
				else if (p == 0 || int'(p) > model_count) r.status = ST_BADPOS;
				else model_slots[(model_head + int'(p) - 1) % DEPTH] = v;
			end
			CMD_SEARCH: begin
				if (model_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int k = 0; k < model_count; k++)
						if (model_slots[(model_head + k) % DEPTH] == v) r.found = 1'b1;
				end
			end
			default: ;
		endcase
		r.entry_count = count_field_t'(model_count);
		return r;
	endfunction

	function automatic int unsigned draw_gap(input bit quiet);
		if (quiet) return 0;
		return $urandom_range(0, 19);
	endfunction

	function automatic value_t draw_value(input int pool_pct);
		if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 11)];
		return value_t'($urandom);
	endfunction

	task automatic add_cmd(input cmd_field_t c, input value_t v, input pos_t p,
			input int unsigned gap, input bit drain);
		deque_cmd_t item;
		item.cmd      = c;
		item.value    = v;
		item.position = p;
		item.gap      = gap;
		item.drain    = drain;
		cmd_pending.push_back(item);
	endtask

	task automatic check_result();
		result_t want;
		if (result_expect.size() == 0) begin
			errors++;
			$display("%0t: unexpected result status=%0d found=%0d count=%0d", $time,
				rsp_ch.status, rsp_ch.found, rsp_ch.entry_count);
		end else begin
			want = result_expect.pop_front();
			results_seen++;
			if (rsp_ch.status !== want.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d, got %0d", $time,
					want.status, rsp_ch.status);
			end
			if (rsp_ch.found !== want.found) begin
				errors++;
				$display("%0t: found mismatch, expected %0d, got %0d", $time,
					want.found, rsp_ch.found);
			end
			if (rsp_ch.entry_count !== want.entry_count) begin
				errors++;
				$display("%0t: entry_count mismatch, expected %0d, got %0d", $time,
					want.entry_count, rsp_ch.entry_count);
			end
			case (want.status)
				ST_FULL:   n_full++;
				ST_EMPTY:  n_empty++;
				ST_BADPOS: n_badpos++;
				default:   ;
			endcase
			if (want.found) n_hits++;
		end
	endtask

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = CMD_PUSH_FRONT;
		req_ch.value     = '0;
		req_ch.position  = '0;
		rsp_ch.ready     = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
	end

	initial forever #1 clk = ~clk;

	// Command driver: one beat per pending item, gap counted before each offer
	always @(negedge clk) begin
		if (arst_n) begin
			drv_offer = req_ch.valid && !req_beat;
			if (!drv_offer && cmd_pending.size() != 0) begin
				if (cmd_pending[0].drain && result_expect.size() != 0) begin
					drv_wait = 0;
				end else if (drv_wait < cmd_pending[0].gap) begin
					drv_wait++;
				end else begin
					req_ch.cmd      <= cmd_pending[0].cmd;
					req_ch.value    <= cmd_pending[0].value;
					req_ch.position <= cmd_pending[0].position;
					void'(cmd_pending.pop_front());
					drv_offer = 1'b1;
					drv_wait  = 0;
				end
			end
			req_ch.valid <= drv_offer;
		end
	end

	// Result receiver: random back-pressure, zero-wait bursts, one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				rcv_ready = 1'b0;
			end else if (!stall_done && cmds_taken > stall_at) begin
				stall_done = 1'b1;
				stall_left = LONG_STALL;
				rcv_ready  = 1'b0;
			end else begin
				if (rsp_beat) begin
					if (rcv_burst > 0) rcv_burst--;
					else if ($urandom_range(0, 9) == 0) rcv_burst = 40;
					rcv_wait = (rcv_burst > 0) ? 0 : $urandom_range(0, 19);
					rcv_cnt  = 0;
				end
				if (rcv_cnt >= rcv_wait) begin
					rcv_ready = 1'b1;
				end else begin
					rcv_ready = 1'b0;
					rcv_cnt++;
				end
			end
			rsp_ch.ready <= rcv_ready;
		end
	end

	// Monitor: results are checked before the command of the same edge is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			req_beat <= req_ch.valid && req_ch.ready;
			rsp_beat <= rsp_ch.valid && rsp_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) check_result();
			if (req_ch.valid && req_ch.ready) begin
				result_expect.push_back(deque_apply(req_ch.cmd, req_ch.value,
					req_ch.position));
				cmds_taken++;
				if (req_ch.cmd == CMD_SEARCH) n_search++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
					idle_cycles, result_expect.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int          made;
		int          seg_len;
		int          seg_kind;
		int          roll;
		bit          quiet;
		bit          first;
		cmd_field_t  c;
		pos_t        p;

		model_head  = 0;
		model_count = 0;
		foreach (model_slots[i]) model_slots[i] = '0;
		drv_wait    = 0;
		rcv_wait    = $urandom_range(0, 19);
		rcv_cnt     = 0;
		rcv_burst   = 0;
		stall_left  = 0;
		stall_done  = 1'b0;
		idle_cycles = 0;
		req_beat    = 1'b0;
		rsp_beat    = 1'b0;

		value_pool[0] = 32'sd0;
		value_pool[1] = -32'sd1;
		value_pool[2] = 32'sd1;
		value_pool[3] = 32'h8000_0000;
		value_pool[4] = 32'h7fff_ffff;
		value_pool[5] = 32'h5555_5555;
		value_pool[6] = 32'haaaa_aaaa;
		for (int i = 7; i < 12; i++) value_pool[i] = value_t'($urandom);

		// Directed: empty cases, ignored codes, extremes, position range
		add_cmd(CMD_SEARCH,     32'sd0,        8'd0,   2, 1'b0);
		add_cmd(CMD_POP_FRONT,  32'sd0,        8'd0,   0, 1'b0);
		add_cmd(CMD_POP_BACK,   32'sd0,        8'd0,   3, 1'b0);
		add_cmd(CMD_REPLACE,    32'sd5,        8'd1,   0, 1'b0);
		add_cmd(CMD_UNUSED_6,   32'sd9,        8'd1,   1, 1'b0);
		add_cmd(CMD_UNUSED_7,   -32'sd1,       8'd255, 0, 1'b0);
		add_cmd(CMD_PUSH_FRONT, 32'h8000_0000, 8'd0,   0, 1'b0);
		add_cmd(CMD_PUSH_BACK,  32'h7fff_ffff, 8'd255, 4, 1'b0);
		add_cmd(CMD_PUSH_FRONT, -32'sd1,       8'd0,   0, 1'b0);
		add_cmd(CMD_SEARCH,     32'h7fff_ffff, 8'd0,   0, 1'b0);
		add_cmd(CMD_SEARCH,     32'sd12345,    8'd0,   5, 1'b0);
		add_cmd(CMD_REPLACE,    32'sd7,        8'd0,   0, 1'b0);
		add_cmd(CMD_REPLACE,    32'sd7,        8'd4,   0, 1'b0);
		add_cmd(CMD_REPLACE,    32'sd7,        8'd255, 2, 1'b0);
		add_cmd(CMD_REPLACE,    32'sd0,        8'd1,   0, 1'b0);
		add_cmd(CMD_REPLACE,    32'h5555_5555, 8'd3,   0, 1'b0);
		add_cmd(CMD_SEARCH,     32'h5555_5555, 8'd0,   1, 1'b0);
		add_cmd(CMD_SEARCH,     32'h8000_0000, 8'd0,   0, 1'b0);
		add_cmd(CMD_POP_FRONT,  32'sd0,        8'd0,   0, 1'b0);
		add_cmd(CMD_POP_BACK,   32'sd0,        8'd0,   6, 1'b0);
		add_cmd(CMD_PUSH_BACK,  32'sd0,        8'd0,   0, 1'b0);
		add_cmd(CMD_POP_BACK,   32'sd0,        8'd0,   0, 1'b0);
		add_cmd(CMD_POP_FRONT,  32'sd0,        8'd0,   0, 1'b0);
		stall_at = cmd_pending.size();

		// Back-to-back fill past full as the hold-off starts; search, replace, then empty it
		for (int i = 0; i < 18; i++)
			add_cmd(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, draw_value(60), 8'd0, 0, i == 0);
		for (int i = 0; i < 4; i++)
			add_cmd(CMD_SEARCH, draw_value(70), 8'd0, 0, 1'b0);
		add_cmd(CMD_REPLACE, draw_value(50), 8'd16, 0, 1'b0);
		add_cmd(CMD_REPLACE, draw_value(50), 8'd17, 0, 1'b0);
		for (int i = 0; i < 18; i++)
			add_cmd(i[0] ? CMD_POP_BACK : CMD_POP_FRONT, draw_value(0), 8'd0, 0, 1'b0);

		// Random segments, each biased toward filling, emptying or mixed traffic
		made  = 0;
		first = 1'b1;
		while (made < RANDOM_ITEMS) begin
			seg_kind = $urandom_range(0, 2);
			seg_len  = $urandom_range(20, 50);
			quiet    = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < seg_len; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					c = $urandom_range(0, 1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
				end else begin
					roll = $urandom_range(0, 99);
					case (seg_kind)
						0: c = (roll < 65) ? ($urandom_range(0, 1) ? CMD_PUSH_FRONT
							: CMD_PUSH_BACK)
							: (roll < 75) ? ($urandom_range(0, 1) ? CMD_POP_FRONT
							: CMD_POP_BACK)
							: (roll < 87) ? CMD_REPLACE : CMD_SEARCH;
						1: c = (roll < 20) ? ($urandom_range(0, 1) ? CMD_PUSH_FRONT
							: CMD_PUSH_BACK)
							: (roll < 70) ? ($urandom_range(0, 1) ? CMD_POP_FRONT
							: CMD_POP_BACK)
							: (roll < 85) ? CMD_REPLACE : CMD_SEARCH;
						default: c = cmd_field_t'($urandom_range(0, 5));
					endcase
					made++;
				end
				p = ($urandom_range(0, 4) == 0) ? pos_t'($urandom_range(0, 255))
					: pos_t'($urandom_range(0, 17));
				add_cmd(c, draw_value(c == CMD_SEARCH ? 80 : 65), p, draw_gap(quiet),
					first || ($urandom_range(0, 29) == 0));
				first = 1'b0;
			end
		end

		wait (arst_n === 1'b1);
		while (cmd_pending.size() != 0 || req_ch.valid) @(posedge clk);
		while (result_expect.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (result_expect.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time, result_expect.size());
		end

		$display("Ran %0d commands, checked %0d results: %0d full, %0d empty, %0d bad position",
			cmds_taken, results_seen, n_full, n_empty, n_badpos);
		$display("Searches issued %0d with %0d hits; long output hold-off and drain pauses done",
			n_search, n_hits);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
